### design/vat_pkg.sv
// ----------------------------------------------------------------------------
// vat_pkg
// Shared types, constants and helpers for the viewbox aspect transform.
// ----------------------------------------------------------------------------
package vat_pkg;

   // default number of fraction bits in all fixed point values
   localparam int FRAC_BITS_DEF = 16;

   // tolerance in lsb for the nearness tests
   localparam logic [31:0] NEAR_TOL = 32'd1;

   // register port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // viewport sizes are 31 bits wide
   localparam int PORT_W = 31;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BOX_LEFT   = 3'd0,
      CSR_BOX_TOP    = 3'd1,
      CSR_BOX_WIDTH  = 3'd2,
      CSR_BOX_HEIGHT = 3'd3,
      CSR_ALIGN_MODE = 3'd4,
      CSR_CLIP_MODE  = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ALIGN_NONE     = 4'd0,
      ALIGN_XMIN_YMIN = 4'd1,
      ALIGN_XMID_YMIN = 4'd2,
      ALIGN_XMAX_YMIN = 4'd3,
      ALIGN_XMIN_YMID = 4'd4,
      ALIGN_XMID_YMID = 4'd5,
      ALIGN_XMAX_YMID = 4'd6,
      ALIGN_XMIN_YMAX = 4'd7,
      ALIGN_XMID_YMAX = 4'd8,
      ALIGN_XMAX_YMAX = 4'd9
   } align_type;

   localparam logic CLIP_MEET  = 1'b0;
   localparam logic CLIP_SLICE = 1'b1;

   typedef enum logic [1:0] {
      POS_MIN = 2'd0,
      POS_MID = 2'd1,
      POS_MAX = 2'd2
   } pos_type;

   typedef struct packed {
      pos_type x;
      pos_type y;
   } place_type;

   // one input word as it travels down the pipeline
   typedef struct packed {
      logic signed [31:0] port_x;
      logic signed [31:0] port_y;
      logic [PORT_W-1:0]  port_width;
      logic [PORT_W-1:0]  port_height;
      logic [31:0]        snap_scale;
   } req_word_type;

   // chosen scales and box placement
   typedef struct packed {
      logic [31:0] scale_x;
      logic [31:0] scale_y;
      place_type   pos;
   } fit_type;

   // placement per axis for an align code; unknown codes place at min
   function automatic place_type align_place(input logic [3:0] code);
      place_type p;
      p = '{x: POS_MIN, y: POS_MIN};
      case (code)
         ALIGN_XMIN_YMIN: p = '{x: POS_MIN, y: POS_MIN};
         ALIGN_XMID_YMIN: p = '{x: POS_MID, y: POS_MIN};
         ALIGN_XMAX_YMIN: p = '{x: POS_MAX, y: POS_MIN};
         ALIGN_XMIN_YMID: p = '{x: POS_MIN, y: POS_MID};
         ALIGN_XMID_YMID: p = '{x: POS_MID, y: POS_MID};
         ALIGN_XMAX_YMID: p = '{x: POS_MAX, y: POS_MID};
         ALIGN_XMIN_YMAX: p = '{x: POS_MIN, y: POS_MAX};
         ALIGN_XMID_YMAX: p = '{x: POS_MID, y: POS_MAX};
         ALIGN_XMAX_YMAX: p = '{x: POS_MAX, y: POS_MAX};
         default:         p = '{x: POS_MIN, y: POS_MIN};
      endcase
      return p;
   endfunction

endpackage

### design/vat_if.sv
// ----------------------------------------------------------------------------
// vat_if
// Request and response channel interfaces of the viewbox aspect transform.
// ----------------------------------------------------------------------------
interface vat_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] port_x;
   logic signed [31:0] port_y;
   logic [30:0]        port_width;
   logic [30:0]        port_height;
   logic [31:0]        snap_scale;

   modport source (output valid, output port_x, output port_y, output port_width,
                   output port_height, output snap_scale, input ready);
   modport sink (input valid, input port_x, input port_y, input port_width,
                 input port_height, input snap_scale, output ready);
endinterface

interface vat_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        scale_horiz;
   logic [31:0]        scale_vert;
   logic signed [31:0] shift_horiz;
   logic signed [31:0] shift_vert;

   modport source (output valid, output scale_horiz, output scale_vert,
                   output shift_horiz, output shift_vert, input ready);
   modport sink (input valid, input scale_horiz, input scale_vert,
                 input shift_horiz, input shift_vert, output ready);
endinterface

### design/vat_div_pipe.sv
// ----------------------------------------------------------------------------
// vat_div_pipe
// Two-lane pipelined restoring divider: one quotient bit per stage for
// port_width / box_width and port_height / box_height.
// ----------------------------------------------------------------------------
module vat_div_pipe #(
   parameter int FRAC_BITS = vat_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  vat_pkg::req_word_type       in_word,
   input  logic [vat_pkg::PORT_W-1:0]  box_width,
   input  logic [vat_pkg::PORT_W-1:0]  box_height,
   output logic                        out_valid,
   output vat_pkg::req_word_type       out_word,
   output logic [vat_pkg::PORT_W+FRAC_BITS-1:0] quo_x,
   output logic [vat_pkg::PORT_W+FRAC_BITS-1:0] quo_y
);
   import vat_pkg::*;

   localparam int DW = PORT_W + FRAC_BITS;
   localparam int NS = DW;

   logic               vld_ff  [NS];
   req_word_type       word_ff [NS];
   logic [DW-1:0]      num_ff  [NS][2];
   logic [DW-1:0]      quo_ff  [NS][2];
   logic [PORT_W-1:0]  rem_ff  [NS][2];
   logic [PORT_W-1:0]  den     [2];

   assign den[0] = box_width;
   assign den[1] = box_height;

   genvar s, l;
   for (s = 0; s < NS; s++) begin : g_stage
      logic              vld_prev;
      req_word_type      word_prev;
      logic [DW-1:0]     num_prev [2];
      logic [DW-1:0]     quo_prev [2];
      logic [PORT_W-1:0] rem_prev [2];

      // stage inputs: request word at the head, previous stage elsewhere
      if (s == 0) begin : g_head
         assign vld_prev    = in_valid;
         assign word_prev   = in_word;
         assign num_prev[0] = {in_word.port_width, {FRAC_BITS{1'b0}}};
         assign num_prev[1] = {in_word.port_height, {FRAC_BITS{1'b0}}};
         assign quo_prev[0] = '0;
         assign quo_prev[1] = '0;
         assign rem_prev[0] = '0;
         assign rem_prev[1] = '0;
      end else begin : g_body
         assign vld_prev    = vld_ff[s-1];
         assign word_prev   = word_ff[s-1];
         assign num_prev[0] = num_ff[s-1][0];
         assign num_prev[1] = num_ff[s-1][1];
         assign quo_prev[0] = quo_ff[s-1][0];
         assign quo_prev[1] = quo_ff[s-1][1];
         assign rem_prev[0] = rem_ff[s-1][0];
         assign rem_prev[1] = rem_ff[s-1][1];
      end

      // one trial subtract per lane
      for (l = 0; l < 2; l++) begin : g_lane
         logic [PORT_W:0] trial;
         logic [PORT_W:0] diff;
         logic            fits;

         assign trial = {rem_prev[l], num_prev[l][DW-1]};
         assign diff  = trial - {1'b0, den[l]};
         assign fits  = (trial >= {1'b0, den[l]});

         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[s][l] <= fits ? diff[PORT_W-1:0] : trial[PORT_W-1:0];
               num_ff[s][l] <= {num_prev[l][DW-2:0], 1'b0};
               quo_ff[s][l] <= {quo_prev[l][DW-2:0], fits};
            end
         end
      end

      // valid bit and word travel with the lanes
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (advance) begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            word_ff[s] <= word_prev;
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_word  = word_ff[NS-1];
   assign quo_x     = quo_ff[NS-1][0];
   assign quo_y     = quo_ff[NS-1][1];

endmodule

### design/vat_fit.sv
// ----------------------------------------------------------------------------
// vat_fit
// Two stages that saturate the quotients and pick the final scales and
// the placement of the box on each axis.
// ----------------------------------------------------------------------------
module vat_fit #(
   parameter int FRAC_BITS = vat_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  vat_pkg::req_word_type       in_word,
   input  logic [vat_pkg::PORT_W+FRAC_BITS-1:0] quo_x,
   input  logic [vat_pkg::PORT_W+FRAC_BITS-1:0] quo_y,
   input  logic [3:0]                  align_mode,
   input  logic                        clip_mode,
   output logic                        out_valid,
   output vat_pkg::req_word_type       out_word,
   output vat_pkg::fit_type            out_fit
);
   import vat_pkg::*;

   localparam int DW = PORT_W + FRAC_BITS;

   // stage a: saturate, compare, mean, min or max
   logic [31:0]  sx;
   logic [31:0]  sy;
   logic [31:0]  dxy;
   logic [32:0]  sum_xy;
   logic [31:0]  a_mean_in;
   logic [31:0]  a_pick_in;
   logic         a_near_in;

   logic         a_vld_ff;
   req_word_type a_word_ff;
   logic [31:0]  a_sx_ff;
   logic [31:0]  a_sy_ff;
   logic [31:0]  a_mean_ff;
   logic [31:0]  a_pick_ff;
   logic         a_near_ff;

   assign sx        = (|quo_x[DW-1:32]) ? '1 : quo_x[31:0];
   assign sy        = (|quo_y[DW-1:32]) ? '1 : quo_y[31:0];
   assign dxy       = (sx > sy) ? (sx - sy) : (sy - sx);
   assign a_near_in = (dxy <= NEAR_TOL);
   assign sum_xy    = {1'b0, sx} + {1'b0, sy};
   assign a_mean_in = sum_xy[32:1];
   assign a_pick_in = (clip_mode == CLIP_SLICE) ? ((sx > sy) ? sx : sy)
                                                : ((sx < sy) ? sx : sy);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (advance) begin
         a_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_word_ff <= in_word;
         a_sx_ff   <= sx;
         a_sy_ff   <= sy;
         a_mean_ff <= a_mean_in;
         a_pick_ff <= a_pick_in;
         a_near_ff <= a_near_in;
      end
   end

   // stage b: snap the mean, or force a uniform scale and place the box, or keep both scales when align is none
   logic [31:0] dms;
   logic        near_snap;
   logic [31:0] uni;
   fit_type     b_fit_in;
   logic        b_vld_ff;
   req_word_type b_word_ff;
   fit_type     b_fit_ff;

   assign dms       = (a_mean_ff > a_word_ff.snap_scale) ? (a_mean_ff - a_word_ff.snap_scale)
                                                         : (a_word_ff.snap_scale - a_mean_ff);
   assign near_snap = (dms <= NEAR_TOL);
   assign uni       = near_snap ? a_word_ff.snap_scale : a_mean_ff;

   always_comb begin
      b_fit_in = '{scale_x: a_sx_ff, scale_y: a_sy_ff, pos: '{x: POS_MIN, y: POS_MIN}};
      if (a_near_ff) begin
         b_fit_in.scale_x = uni;
         b_fit_in.scale_y = uni;
      end else if (align_mode != ALIGN_NONE) begin
         b_fit_in.scale_x = a_pick_ff;
         b_fit_in.scale_y = a_pick_ff;
         b_fit_in.pos     = align_place(align_mode);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (advance) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_word_ff <= a_word_ff;
         b_fit_ff  <= b_fit_in;
      end
   end

   assign out_valid = b_vld_ff;
   assign out_word  = b_word_ff;
   assign out_fit   = b_fit_ff;

endmodule

### design/vat_place.sv
// ----------------------------------------------------------------------------
// vat_place
// Three stages: products of scale and box, placement offsets, then the
// saturated translations in the output register.
// ----------------------------------------------------------------------------
module vat_place #(
   parameter int FRAC_BITS = vat_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  vat_pkg::req_word_type       in_word,
   input  vat_pkg::fit_type            in_fit,
   input  logic signed [31:0]          box_left,
   input  logic signed [31:0]          box_top,
   input  logic [vat_pkg::PORT_W-1:0]  box_width,
   input  logic [vat_pkg::PORT_W-1:0]  box_height,
   output logic                        out_valid,
   output logic [31:0]                 scale_horiz,
   output logic [31:0]                 scale_vert,
   output logic signed [31:0]          shift_horiz,
   output logic signed [31:0]          shift_vert
);
   import vat_pkg::*;

   // stage c: one multiplier per product
   logic [62:0]         c_size_x_in;
   logic [62:0]         c_size_y_in;
   logic signed [64:0]  c_org_x_in;
   logic signed [64:0]  c_org_y_in;

   logic                c_vld_ff;
   req_word_type        c_word_ff;
   fit_type             c_fit_ff;
   logic [62:0]         c_size_x_ff;
   logic [62:0]         c_size_y_ff;
   logic signed [64:0]  c_org_x_ff;
   logic signed [64:0]  c_org_y_ff;

   assign c_size_x_in = 63'(box_width) * 63'(in_fit.scale_x);
   assign c_size_y_in = 63'(box_height) * 63'(in_fit.scale_y);
   assign c_org_x_in  = $signed({1'b0, in_fit.scale_x}) * box_left;
   assign c_org_y_in  = $signed({1'b0, in_fit.scale_y}) * box_top;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (advance) begin
         c_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_word_ff   <= in_word;
         c_fit_ff    <= in_fit;
         c_size_x_ff <= c_size_x_in;
         c_size_y_ff <= c_size_y_in;
         c_org_x_ff  <= c_org_x_in;
         c_org_y_ff  <= c_org_y_in;
      end
   end

   // stage d: free space and offset per axis, floored box origin term
   function automatic logic signed [63:0] offset_of(input pos_type pos,
                                                    input logic [PORT_W-1:0] port,
                                                    input logic [62:0] size);
      logic signed [63:0] free_space;
      logic signed [63:0] off;
      free_space = $signed(64'(port)) - $signed({1'b0, size >> FRAC_BITS});
      case (pos)
         POS_MID: off = free_space >>> 1;
         POS_MAX: off = free_space;
         default: off = '0;
      endcase
      return off;
   endfunction

   logic                d_vld_ff;
   req_word_type        d_word_ff;
   fit_type             d_fit_ff;
   logic signed [63:0]  d_off_x_ff;
   logic signed [63:0]  d_off_y_ff;
   logic signed [64:0]  d_org_x_ff;
   logic signed [64:0]  d_org_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (advance) begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_word_ff  <= c_word_ff;
         d_fit_ff   <= c_fit_ff;
         d_off_x_ff <= offset_of(c_fit_ff.pos.x, c_word_ff.port_width, c_size_x_ff);
         d_off_y_ff <= offset_of(c_fit_ff.pos.y, c_word_ff.port_height, c_size_y_ff);
         d_org_x_ff <= c_org_x_ff >>> FRAC_BITS;
         d_org_y_ff <= c_org_y_ff >>> FRAC_BITS;
      end
   end

   // stage e: origin + offset - box term, clamped to 32 bits signed
   function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
      logic signed [31:0] r;
      if ((v[66:31] == '0) || (v[66:31] == '1)) begin
         r = v[31:0];
      end else if (v[66]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

   logic signed [66:0]  sum_x;
   logic signed [66:0]  sum_y;
   logic                e_vld_ff;
   logic [31:0]         e_scale_x_ff;
   logic [31:0]         e_scale_y_ff;
   logic signed [31:0]  e_shift_x_ff;
   logic signed [31:0]  e_shift_y_ff;

   assign sum_x = 67'(d_word_ff.port_x) + 67'(d_off_x_ff) - 67'(d_org_x_ff);
   assign sum_y = 67'(d_word_ff.port_y) + 67'(d_off_y_ff) - 67'(d_org_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (advance) begin
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e_scale_x_ff <= d_fit_ff.scale_x;
         e_scale_y_ff <= d_fit_ff.scale_y;
         e_shift_x_ff <= sat32(sum_x);
         e_shift_y_ff <= sat32(sum_y);
      end
   end

   assign out_valid   = e_vld_ff;
   assign scale_horiz = e_scale_x_ff;
   assign scale_vert  = e_scale_y_ff;
   assign shift_horiz = e_shift_x_ff;
   assign shift_vert  = e_shift_y_ff;

endmodule

### design/viewbox_aspect_transform.sv
// ----------------------------------------------------------------------------
// viewbox_aspect_transform
// The divider works one quotient bit per stage over 31 + FRAC_BITS stages
// (Q16.16 scales at the default FRAC_BITS of 16).
// Throughput: one word per cycle; the whole pipeline holds while a response waits.
// Reset clears all valid bits and loads the registers with their defaults.
// ----------------------------------------------------------------------------
module viewbox_aspect_transform #(
   parameter int FRAC_BITS = vat_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [vat_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [vat_pkg::CSR_DATA_W-1:0]   csr_data,
   vat_req_if.sink                          req,
   vat_rsp_if.source                        rsp
);
   import vat_pkg::*;

   localparam int DW = PORT_W + FRAC_BITS;

   // configuration registers
   logic signed [31:0]  box_left_ff;
   logic signed [31:0]  box_top_ff;
   logic [PORT_W-1:0]   box_width_ff;
   logic [PORT_W-1:0]   box_height_ff;
   logic [3:0]          align_ff;
   logic                clip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_left_ff   <= '0;
         box_top_ff    <= '0;
         box_width_ff  <= PORT_W'(64'd1 << FRAC_BITS);
         box_height_ff <= PORT_W'(64'd1 << FRAC_BITS);
         align_ff      <= ALIGN_XMID_YMID;
         clip_ff       <= CLIP_MEET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_BOX_LEFT:   box_left_ff   <= csr_data;
            CSR_BOX_TOP:    box_top_ff    <= csr_data;
            CSR_BOX_WIDTH:  box_width_ff  <= csr_data[PORT_W-1:0];
            CSR_BOX_HEIGHT: box_height_ff <= csr_data[PORT_W-1:0];
            CSR_ALIGN_MODE: align_ff      <= csr_data[3:0];
            CSR_CLIP_MODE:  clip_ff       <= csr_data[0];
            default:        ;
         endcase
      end
   end

   // pipeline moves whenever the output register is free or being drained
   logic advance;
   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   req_word_type req_word;
   assign req_word = '{port_x: req.port_x, port_y: req.port_y,
                       port_width: req.port_width, port_height: req.port_height,
                       snap_scale: req.snap_scale};

   // divider
   logic          div_valid;
   req_word_type  div_word;
   logic [DW-1:0] quo_x;
   logic [DW-1:0] quo_y;

   vat_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req.valid),
      .in_word    (req_word),
      .box_width  (box_width_ff),
      .box_height (box_height_ff),
      .out_valid  (div_valid),
      .out_word   (div_word),
      .quo_x      (quo_x),
      .quo_y      (quo_y)
   );

   // scale selection
   logic          fit_valid;
   req_word_type  fit_word;
   fit_type       fit;

   vat_fit #(.FRAC_BITS(FRAC_BITS)) u_fit (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (div_valid),
      .in_word    (div_word),
      .quo_x      (quo_x),
      .quo_y      (quo_y),
      .align_mode (align_ff),
      .clip_mode  (clip_ff),
      .out_valid  (fit_valid),
      .out_word   (fit_word),
      .out_fit    (fit)
   );

   // placement and translations
   vat_place #(.FRAC_BITS(FRAC_BITS)) u_place (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (fit_valid),
      .in_word     (fit_word),
      .in_fit      (fit),
      .box_left    (box_left_ff),
      .box_top     (box_top_ff),
      .box_width   (box_width_ff),
      .box_height  (box_height_ff),
      .out_valid   (rsp.valid),
      .scale_horiz (rsp.scale_horiz),
      .scale_vert  (rsp.scale_vert),
      .shift_horiz (rsp.shift_horiz),
      .shift_vert  (rsp.shift_vert)
   );

   // checks
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("response valid after reset");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (rsp.valid && !rsp.ready))
      else $error("request stalled with free output register");

   a_uniform_when_aligned: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (align_ff != ALIGN_NONE)) |-> (rsp.scale_horiz == rsp.scale_vert))
      else $error("non-uniform scale with an align mode set");

endmodule
